FILE: rtl/assert_macros.svh
// Assertion macros for the clipper
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising clock edge, off during reset
`define ASSERT_CLK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked at every rising clock edge, reset included
`define ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

FILE: rtl/ccp_pkg.sv
`default_nettype none
package ccp_pkg;
   localparam int MAX_VERTICES = 16;
   localparam int MAX_WINDOW   = 7;
   localparam int NUM_WIN_REGS = 7;
   localparam int VIDX_W = $clog2(MAX_VERTICES);
   localparam int CNT_W  = $clog2(MAX_VERTICES + 1);

   localparam logic [3:0] CSR_WINDOW_COUNT    = 4'd0;
   localparam logic [3:0] CSR_WINDOW_VERTEX_0 = 4'd1;
   localparam logic [3:0] CSR_WINDOW_VERTEX_6 = 4'd7;

   typedef struct packed {
      logic signed [15:0] x;
      logic signed [15:0] y;
   } vertex_type;
endpackage
`default_nettype wire

FILE: rtl/convex_polygon_clipper.sv
// Convex polygon clipper (Sutherland-Hodgman).
// Requests: one subject vertex per request, taken at a rising edge with
// start high and busy low. The vertex with req_vert_last set starts the clip;
// busy stays high from then until the last result has been shown.
// Window: csr_wr_en writes register csr_index (0 = window count, 1..7 =
// window vertices, x in 31:16, y in 15:0); other indexes are ignored.
// Results: rsp_strobe marks each clipped vertex for exactly one cycle;
// rsp_out_last marks the final one. The receiver cannot stall, so results
// leave at one per cycle. An empty result is one item with empty and last set.
// Sequence: a non-last vertex is only stored and busy stays low. After the
// last vertex, per window edge: the edge setup (window vertices, line
// coefficients, reference side), then per buffered vertex a side test and a
// decision, a write per vertex written out and an x and a y division per
// crossing (shared multiplier, 17-step restoring divider), and a step to
// close the edge; then the results are shown.
// Reset (synchronous, active high) clears counts and flags, sets window
// count to 3 and all window vertices to zero; buffers hold no valid data.
`default_nettype none
module convex_polygon_clipper
   import ccp_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire logic signed [15:0] req_vert_x,
   input  wire logic signed [15:0] req_vert_y,
   input  wire logic               req_vert_last,
   input  wire logic               csr_wr_en,
   input  wire logic [3:0]         csr_index,
   input  wire logic [31:0]        csr_wr_data,
   output logic                    rsp_strobe,
   output logic signed [15:0]      rsp_out_x,
   output logic signed [15:0]      rsp_out_y,
   output logic                    rsp_out_last,
   output logic                    rsp_out_empty,
   output logic                    rsp_out_overflow
);
`include "assert_macros.svh"

   localparam logic [4:0] ST_IDLE  = 5'd0;
   localparam logic [4:0] ST_EDGE  = 5'd1;
   localparam logic [4:0] ST_EW1   = 5'd2;
   localparam logic [4:0] ST_EW2   = 5'd3;
   localparam logic [4:0] ST_C1    = 5'd4;
   localparam logic [4:0] ST_C2    = 5'd5;
   localparam logic [4:0] ST_C3    = 5'd6;
   localparam logic [4:0] ST_P1    = 5'd7;
   localparam logic [4:0] ST_P2    = 5'd8;
   localparam logic [4:0] ST_P3    = 5'd9;
   localparam logic [4:0] ST_VTX   = 5'd10;
   localparam logic [4:0] ST_DEC   = 5'd11;
   localparam logic [4:0] ST_X1    = 5'd12;
   localparam logic [4:0] ST_X2    = 5'd13;
   localparam logic [4:0] ST_X3    = 5'd14;
   localparam logic [4:0] ST_DIV   = 5'd15;
   localparam logic [4:0] ST_PUSHX = 5'd16;
   localparam logic [4:0] ST_PUSHB = 5'd17;
   localparam logic [4:0] ST_NEXT  = 5'd18;
   localparam logic [4:0] ST_OUT   = 5'd19;

   localparam logic [1:0] SD_REF   = 2'd0;
   localparam logic [1:0] SD_FIRST = 2'd1;
   localparam logic [1:0] SD_B     = 2'd2;

   logic [4:0]         state_ff, state_in;
   logic [2:0]         win_cnt_ff;
   vertex_type         win_vtx_ff [NUM_WIN_REGS];
   vertex_type         vbuf_ff [2][MAX_VERTICES];
   logic               cur_ff, cur_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in, ocnt_ff, ocnt_in;
   logic               ovf_ff, ovf_in;
   logic [2:0]         edge_ff, edge_in;
   logic [CNT_W-1:0]   i_ff, i_in;
   vertex_type         e0_ff, e0_in, e1_ff, e1_in, r_ff, r_in;
   vertex_type         pt_ff, pt_in, a_ff, a_in, b_ff, b_in;
   logic signed [16:0] coef_a_ff, coef_a_in, coef_b_ff, coef_b_in;
   logic signed [33:0] c_ff, c_in;
   logic signed [52:0] prod_ff;
   logic signed [53:0] acc_ff, acc_in;
   logic [1:0]         tgt_ff, tgt_in;
   logic               sr_pos_ff, sr_pos_in, sr_neg_ff, sr_neg_in;
   logic signed [35:0] dprev_ff, dprev_in, dfirst_ff, dfirst_in, db_ff, db_in;
   logic               outa_ff, outa_in;
   logic               axis_ff, axis_in;
   logic [53:0]        rem_ff, rem_in, dv_ff, dv_in;
   logic [16:0]        q_ff, q_in;
   logic               qneg_ff, qneg_in;
   logic [4:0]         dcnt_ff, dcnt_in;
   logic signed [15:0] qx_ff, qx_in;

   logic signed [35:0] mul_a;
   logic signed [16:0] mul_b;
   logic [2:0]         wc, win_idx;
   logic [3:0]         e1_sum, e2_sum;
   logic [VIDX_W-1:0]  rd_idx;
   vertex_type         rd_vtx;
   logic               wr_en, wr_bank;
   logic [VIDX_W-1:0]  wr_idx;
   vertex_type         wr_data;
   logic signed [53:0] acc_m_prod, acc_p_prod;
   logic signed [36:0] den;
   logic [53:0]        num_mag;
   logic [36:0]        den_mag;
   logic               ge;
   logic [16:0]        q_fin, q_sgn;
   logic               out_a, out_b;
   logic signed [15:0] bcoord, acoord;

   assign wc     = (win_cnt_ff < 3'd3) ? 3'd3 : win_cnt_ff;
   assign e1_sum = {1'b0, edge_ff} + 4'd1;
   assign e2_sum = {1'b0, edge_ff} + 4'd2;
   assign rd_vtx = vbuf_ff[cur_ff][rd_idx];

   always_comb begin
      win_idx = edge_ff;
      if (state_ff == ST_EW1) begin
         win_idx = (e1_sum >= {1'b0, wc}) ? 3'(e1_sum - {1'b0, wc}) : e1_sum[2:0];
      end else if (state_ff == ST_EW2) begin
         win_idx = (e2_sum >= {1'b0, wc}) ? 3'(e2_sum - {1'b0, wc}) : e2_sum[2:0];
      end
   end

   always_comb begin
      rd_idx = '0;
      if (state_ff == ST_VTX) begin
         rd_idx = (i_ff + 1'b1 == cnt_ff) ? '0 : VIDX_W'(i_ff + 1'b1);
      end else if (state_ff == ST_OUT) begin
         rd_idx = i_ff[VIDX_W-1:0];
      end
   end

   assign bcoord = axis_ff ? b_ff.y : b_ff.x;
   assign acoord = axis_ff ? a_ff.y : a_ff.x;

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         ST_C1: begin
            mul_a = 36'(e1_ff.x);
            mul_b = 17'(e0_ff.y);
         end
         ST_C2: begin
            mul_a = 36'(e0_ff.x);
            mul_b = 17'(e1_ff.y);
         end
         ST_P1: begin
            mul_a = 36'(coef_a_ff);
            mul_b = 17'(pt_ff.x);
         end
         ST_P2: begin
            mul_a = 36'(coef_b_ff);
            mul_b = 17'(pt_ff.y);
         end
         ST_X1: begin
            mul_a = dprev_ff;
            mul_b = 17'(bcoord);
         end
         ST_X2: begin
            mul_a = db_ff;
            mul_b = 17'(acoord);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign acc_m_prod = acc_ff - 54'(prod_ff);
   assign acc_p_prod = acc_ff + 54'(prod_ff);
   assign den        = 37'(dprev_ff) - 37'(db_ff);
   assign num_mag    = acc_m_prod[53] ? 54'(-acc_m_prod) : 54'(acc_m_prod);
   assign den_mag    = den[36] ? 37'(-den) : 37'(den);
   assign ge         = rem_ff >= dv_ff;
   assign q_fin      = {q_ff[15:0], ge};
   assign q_sgn      = qneg_ff ? 17'(-q_fin) : q_fin;
   assign out_a = (sr_pos_ff && dprev_ff < 0) || (sr_neg_ff && dprev_ff > 0);
   assign out_b = (sr_pos_ff && db_ff < 0) || (sr_neg_ff && db_ff > 0);

   always_comb begin
      state_in  = state_ff;
      cur_in    = cur_ff;
      cnt_in    = cnt_ff;
      ocnt_in   = ocnt_ff;
      ovf_in    = ovf_ff;
      edge_in   = edge_ff;
      i_in      = i_ff;
      e0_in     = e0_ff;
      e1_in     = e1_ff;
      r_in      = r_ff;
      pt_in     = pt_ff;
      a_in      = a_ff;
      b_in      = b_ff;
      coef_a_in = coef_a_ff;
      coef_b_in = coef_b_ff;
      c_in      = c_ff;
      acc_in    = acc_ff;
      tgt_in    = tgt_ff;
      sr_pos_in = sr_pos_ff;
      sr_neg_in = sr_neg_ff;
      dprev_in  = dprev_ff;
      dfirst_in = dfirst_ff;
      db_in     = db_ff;
      outa_in   = outa_ff;
      axis_in   = axis_ff;
      rem_in    = rem_ff;
      dv_in     = dv_ff;
      q_in      = q_ff;
      qneg_in   = qneg_ff;
      dcnt_in   = dcnt_ff;
      qx_in     = qx_ff;
      wr_en     = 1'b0;
      wr_bank   = cur_ff;
      wr_idx    = '0;
      wr_data   = b_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               wr_data.x = req_vert_x;
               wr_data.y = req_vert_y;
               wr_idx    = cnt_ff[VIDX_W-1:0];
               if (cnt_ff < CNT_W'(MAX_VERTICES)) begin
                  wr_en  = 1'b1;
                  cnt_in = cnt_ff + 1'b1;
               end else begin
                  ovf_in = 1'b1;
               end
               if (req_vert_last) begin
                  edge_in  = '0;
                  state_in = ST_EDGE;
               end
            end
         end
         ST_EDGE: begin
            if (edge_ff == wc || cnt_ff == '0) begin
               i_in     = '0;
               state_in = ST_OUT;
            end else begin
               e0_in    = win_vtx_ff[win_idx];
               state_in = ST_EW1;
            end
         end
         ST_EW1: begin
            e1_in    = win_vtx_ff[win_idx];
            state_in = ST_EW2;
         end
         ST_EW2: begin
            r_in     = win_vtx_ff[win_idx];
            state_in = ST_C1;
         end
         ST_C1: begin
            coef_a_in = 17'(e1_ff.y) - 17'(e0_ff.y);
            coef_b_in = 17'(e0_ff.x) - 17'(e1_ff.x);
            state_in  = ST_C2;
         end
         ST_C2: begin
            acc_in   = 54'(prod_ff);
            state_in = ST_C3;
         end
         ST_C3: begin
            c_in     = acc_m_prod[33:0];
            pt_in    = r_ff;
            tgt_in   = SD_REF;
            state_in = ST_P1;
         end
         ST_P1: begin
            state_in = ST_P2;
         end
         ST_P2: begin
            acc_in   = 54'(c_ff) + 54'(prod_ff);
            state_in = ST_P3;
         end
         ST_P3: begin
            unique case (tgt_ff)
               SD_REF: begin
                  sr_pos_in = acc_p_prod > 0;
                  sr_neg_in = acc_p_prod < 0;
                  pt_in     = rd_vtx;
                  tgt_in    = SD_FIRST;
                  state_in  = ST_P1;
               end
               SD_FIRST: begin
                  dfirst_in = acc_p_prod[35:0];
                  dprev_in  = acc_p_prod[35:0];
                  a_in      = pt_ff;
                  i_in      = '0;
                  ocnt_in   = '0;
                  state_in  = ST_VTX;
               end
               default: begin
                  db_in    = acc_p_prod[35:0];
                  state_in = ST_DEC;
               end
            endcase
         end
         ST_VTX: begin
            if (i_ff == cnt_ff) begin
               cur_in   = ~cur_ff;
               cnt_in   = ocnt_ff;
               edge_in  = edge_ff + 1'b1;
               state_in = ST_EDGE;
            end else if (i_ff + 1'b1 == cnt_ff) begin
               b_in     = rd_vtx;
               db_in    = dfirst_ff;
               state_in = ST_DEC;
            end else begin
               b_in     = rd_vtx;
               pt_in    = rd_vtx;
               tgt_in   = SD_B;
               state_in = ST_P1;
            end
         end
         ST_DEC: begin
            outa_in = out_a;
            axis_in = 1'b0;
            if (!out_a && !out_b) begin
               state_in = ST_PUSHB;
            end else if (out_a && out_b) begin
               state_in = ST_NEXT;
            end else begin
               state_in = ST_X1;
            end
         end
         ST_X1: begin
            state_in = ST_X2;
         end
         ST_X2: begin
            acc_in   = 54'(prod_ff);
            state_in = ST_X3;
         end
         ST_X3: begin
            rem_in   = num_mag;
            dv_in    = {1'b0, den_mag, 16'b0};
            q_in     = '0;
            qneg_in  = acc_m_prod[53] ^ den[36];
            dcnt_in  = 5'd16;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (ge) begin
               rem_in = rem_ff - dv_ff;
            end
            q_in    = q_fin;
            dv_in   = dv_ff >> 1;
            dcnt_in = dcnt_ff - 1'b1;
            if (dcnt_ff == '0) begin
               if (!axis_ff) begin
                  qx_in    = q_sgn[15:0];
                  axis_in  = 1'b1;
                  state_in = ST_X1;
               end else begin
                  b_in.y   = b_ff.y;
                  pt_in.x  = qx_ff;
                  pt_in.y  = q_sgn[15:0];
                  state_in = ST_PUSHX;
               end
            end
         end
         ST_PUSHX, ST_PUSHB: begin
            wr_bank = ~cur_ff;
            wr_idx  = ocnt_ff[VIDX_W-1:0];
            wr_data = (state_ff == ST_PUSHX) ? pt_ff : b_ff;
            if (ocnt_ff < CNT_W'(MAX_VERTICES)) begin
               wr_en   = 1'b1;
               ocnt_in = ocnt_ff + 1'b1;
            end else begin
               ovf_in = 1'b1;
            end
            if (state_ff == ST_PUSHX && outa_ff) begin
               state_in = ST_PUSHB;
            end else begin
               state_in = ST_NEXT;
            end
         end
         ST_NEXT: begin
            a_in     = b_ff;
            dprev_in = db_ff;
            i_in     = i_ff + 1'b1;
            state_in = ST_VTX;
         end
         ST_OUT: begin
            i_in = i_ff + 1'b1;
            if (cnt_ff == '0 || i_ff + 1'b1 == cnt_ff) begin
               cnt_in   = '0;
               ovf_in   = 1'b0;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         cur_ff     <= 1'b0;
         cnt_ff     <= '0;
         ocnt_ff    <= '0;
         ovf_ff     <= 1'b0;
         win_cnt_ff <= 3'd3;
         for (int k = 0; k < NUM_WIN_REGS; k++) begin
            win_vtx_ff[k] <= '0;
         end
      end else begin
         state_ff <= state_in;
         cur_ff   <= cur_in;
         cnt_ff   <= cnt_in;
         ocnt_ff  <= ocnt_in;
         ovf_ff   <= ovf_in;
         if (csr_wr_en) begin
            if (csr_index == CSR_WINDOW_COUNT) begin
               win_cnt_ff <= csr_wr_data[2:0];
            end else if (csr_index >= CSR_WINDOW_VERTEX_0 &&
                         csr_index <= CSR_WINDOW_VERTEX_6) begin
               win_vtx_ff[3'(csr_index - CSR_WINDOW_VERTEX_0)] <= csr_wr_data;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      edge_ff   <= edge_in;
      i_ff      <= i_in;
      e0_ff     <= e0_in;
      e1_ff     <= e1_in;
      r_ff      <= r_in;
      pt_ff     <= pt_in;
      a_ff      <= a_in;
      b_ff      <= b_in;
      coef_a_ff <= coef_a_in;
      coef_b_ff <= coef_b_in;
      c_ff      <= c_in;
      prod_ff   <= mul_a * mul_b;
      acc_ff    <= acc_in;
      tgt_ff    <= tgt_in;
      sr_pos_ff <= sr_pos_in;
      sr_neg_ff <= sr_neg_in;
      dprev_ff  <= dprev_in;
      dfirst_ff <= dfirst_in;
      db_ff     <= db_in;
      outa_ff   <= outa_in;
      axis_ff   <= axis_in;
      rem_ff    <= rem_in;
      dv_ff     <= dv_in;
      q_ff      <= q_in;
      qneg_ff   <= qneg_in;
      dcnt_ff   <= dcnt_in;
      qx_ff     <= qx_in;
      if (wr_en) begin
         vbuf_ff[wr_bank][wr_idx] <= wr_data;
      end
   end

   assign busy             = state_ff != ST_IDLE;
   assign rsp_strobe       = state_ff == ST_OUT;
   assign rsp_out_empty    = rsp_strobe && cnt_ff == '0;
   assign rsp_out_last     = rsp_strobe && (cnt_ff == '0 || i_ff + 1'b1 == cnt_ff);
   assign rsp_out_x        = (rsp_strobe && cnt_ff != '0) ? rd_vtx.x : '0;
   assign rsp_out_y        = (rsp_strobe && cnt_ff != '0) ? rd_vtx.y : '0;
   assign rsp_out_overflow = rsp_strobe && ovf_ff;

   `ASSERT_CLK(a_cnt_range, cnt_ff <= CNT_W'(MAX_VERTICES) && ocnt_ff <= CNT_W'(MAX_VERTICES), "vertex count beyond buffer")
   `ASSERT_CLK(a_empty_last, rsp_out_empty |-> rsp_out_last, "empty result not marked last")
   `ASSERT_CLK(a_nonlast_stays_idle, (start && !busy && !req_vert_last) |=> !busy, "non-last vertex left block busy")
   `ASSERT_CLK(a_last_clears, (rsp_strobe && rsp_out_last) |=> (!busy && cnt_ff == '0 && !ovf_ff), "state not cleared after results")
   `ASSERT_ALWAYS(a_div_entry, (state_ff == ST_DIV && $past(state_ff) == ST_X3) |-> dcnt_ff == 5'd16, "divider started with wrong step count")

endmodule
`default_nettype wire

FILE: tb/convex_polygon_clipper_test.sv
`timescale 1ns / 100ps
`default_nettype none
module convex_polygon_clipper_test;
   import ccp_pkg::*;

   localparam int QUIET_LIMIT = 40000;

   typedef struct {
      logic signed [15:0] x;
      logic signed [15:0] y;
      logic               last;
   } request_t;

   typedef struct {
      logic signed [15:0] x;
      logic signed [15:0] y;
      logic               last;
      logic               empty;
      logic               overflow;
   } clipped_vertex_t;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic signed [15:0] req_vert_x = '0;
   logic signed [15:0] req_vert_y = '0;
   logic req_vert_last = 1'b0;
   logic csr_wr_en = 1'b0;
   logic [3:0] csr_index = '0;
   logic [31:0] csr_wr_data = '0;
   logic rsp_strobe;
   logic signed [15:0] rsp_out_x;
   logic signed [15:0] rsp_out_y;
   logic rsp_out_last;
   logic rsp_out_empty;
   logic rsp_out_overflow;

   convex_polygon_clipper u_dut (
      .clock, .reset, .start, .busy,
      .req_vert_x, .req_vert_y, .req_vert_last,
      .csr_wr_en, .csr_index, .csr_wr_data,
      .rsp_strobe, .rsp_out_x, .rsp_out_y, .rsp_out_last,
      .rsp_out_empty, .rsp_out_overflow
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   request_t        pending_vertices[$];
   clipped_vertex_t expected_vertices[$];
   int  mismatches = 0;
   int  quiet_cycles = 0;
   int  gap_left = 0;
   bit  no_gaps = 1'b0;
   logic took = 1'b0;

   // local copy of window registers and vertex buffer
   logic [2:0]  win_count = 3'd3;
   vertex_type  win_vert[NUM_WIN_REGS];
   vertex_type  subj_buf[MAX_VERTICES];
   int          subj_count = 0;
   bit          subj_overflow = 1'b0;

   task automatic report(input string what);
      $display("%0t mismatch: %s", $realtime, what);
      mismatches++;
   endtask

   function automatic longint side_of_edge(vertex_type e0, vertex_type e1, vertex_type p);
      longint a, b, c;
      a = longint'(e1.y) - longint'(e0.y);
      b = longint'(e0.x) - longint'(e1.x);
      c = longint'(e1.x) * longint'(e0.y) - longint'(e0.x) * longint'(e1.y);
      return a * longint'(p.x) + b * longint'(p.y) + c;
   endfunction

   function automatic int sign_of(longint v);
      return (v > 0) ? 1 : ((v < 0) ? -1 : 0);
   endfunction

   function automatic vertex_type crossing(vertex_type a, vertex_type b, longint da,
                                          longint db);
      vertex_type r;
      longint den;
      den = da - db;
      if (den == 0) return b;
      r.x = 16'((longint'(b.x) * da - longint'(a.x) * db) / den);
      r.y = 16'((longint'(b.y) * da - longint'(a.y) * db) / den);
      return r;
   endfunction

   task automatic push_clipped(inout vertex_type buf_q[MAX_VERTICES], inout int n,
                               input vertex_type v);
      if (n < MAX_VERTICES) begin
         buf_q[n] = v;
         n++;
      end else begin
         subj_overflow = 1'b1;
      end
   endtask

   task automatic clip_against(input vertex_type e0, e1, r);
      vertex_type next_buf[MAX_VERTICES];
      vertex_type a, b;
      int n, sr;
      longint da, db;
      bit out_a, out_b;
      n = 0;
      sr = sign_of(side_of_edge(e0, e1, r));
      for (int i = 0; i < subj_count; i++) begin
         a = subj_buf[i];
         b = subj_buf[(i + 1) % subj_count];
         da = side_of_edge(e0, e1, a);
         db = side_of_edge(e0, e1, b);
         out_a = sr * sign_of(da) < 0;
         out_b = sr * sign_of(db) < 0;
         if (!out_a && !out_b) begin
            push_clipped(next_buf, n, b);
         end else if (out_a && !out_b) begin
            push_clipped(next_buf, n, crossing(a, b, da, db));
            push_clipped(next_buf, n, b);
         end else if (!out_a && out_b) begin
            push_clipped(next_buf, n, crossing(a, b, da, db));
         end
      end
      subj_buf = next_buf;
      subj_count = n;
   endtask

   task automatic take_vertex(input request_t rq);
      int wc;
      clipped_vertex_t cv;
      if (subj_count < MAX_VERTICES) begin
         subj_buf[subj_count] = '{x: rq.x, y: rq.y};
         subj_count++;
      end else begin
         subj_overflow = 1'b1;
      end
      if (rq.last) begin
         wc = (win_count < 3) ? 3 : int'(win_count);
         for (int e = 0; e < wc && subj_count > 0; e++)
            clip_against(win_vert[e], win_vert[(e + 1) % wc], win_vert[(e + 2) % wc]);
         if (subj_count == 0) begin
            cv = '{x: 0, y: 0, last: 1, empty: 1, overflow: subj_overflow};
            expected_vertices.insert(expected_vertices.size(), cv);
         end
         for (int k = 0; k < subj_count; k++) begin
            cv = '{x: subj_buf[k].x, y: subj_buf[k].y, last: k == subj_count - 1,
                   empty: 0, overflow: subj_overflow};
            expected_vertices.insert(expected_vertices.size(), cv);
         end
         subj_count = 0;
         subj_overflow = 1'b0;
      end
   endtask

   // driver
   always @(negedge clock) begin
      request_t rq;
      if (!reset) begin
         if (start && took) void'(pending_vertices.pop_front());
         if (start && !took) begin
            start <= 1'b1;
         end else if (gap_left > 0) begin
            gap_left--;
            start <= 1'b0;
         end else if (pending_vertices.size() > 0 && !no_gaps &&
                      $urandom_range(0, 7) == 0) begin
            gap_left = $urandom_range(0, 16);
            start <= 1'b0;
         end else if (pending_vertices.size() > 0) begin
            rq = pending_vertices[0];
            req_vert_x <= rq.x;
            req_vert_y <= rq.y;
            req_vert_last <= rq.last;
            start <= 1'b1;
         end else begin
            start <= 1'b0;
         end
      end
   end

   // monitor and watchdog
   always @(posedge clock) begin
      clipped_vertex_t cv;
      took <= start && !busy && !reset;
      if (!reset && start && !busy)
         take_vertex('{x: req_vert_x, y: req_vert_y, last: req_vert_last});
      if (!reset && rsp_strobe) begin
         if (expected_vertices.size() == 0) begin
            report("result with nothing expected");
         end else begin
            cv = expected_vertices.pop_front();
            if (rsp_out_x !== cv.x) report($sformatf("x %0d exp %0d", rsp_out_x, cv.x));
            if (rsp_out_y !== cv.y) report($sformatf("y %0d exp %0d", rsp_out_y, cv.y));
            if (rsp_out_last !== cv.last) report("last flag");
            if (rsp_out_empty !== cv.empty) report("empty flag");
            if (rsp_out_overflow !== cv.overflow) report("overflow flag");
         end
      end
      if (reset || (start && !busy) || rsp_strobe) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   task automatic write_reg(input logic [3:0] idx, input logic [31:0] val);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wr_data <= val;
      if (idx == CSR_WINDOW_COUNT) win_count = val[2:0];
      else if (idx <= CSR_WINDOW_VERTEX_6) win_vert[idx - CSR_WINDOW_VERTEX_0] = val;
   endtask

   task automatic set_window(input logic [2:0] cnt, input logic [31:0] v[NUM_WIN_REGS]);
      write_reg(CSR_WINDOW_COUNT, {29'd0, cnt});
      for (int k = 0; k < NUM_WIN_REGS; k++)
         write_reg(CSR_WINDOW_VERTEX_0 + 4'(k), v[k]);
      write_reg(4'(CSR_WINDOW_VERTEX_6 + 1 + $urandom_range(0, 7)), $urandom);
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic add_vertex(input int x, input int y, input bit last);
      request_t rq;
      rq = '{x: 16'(x), y: 16'(y), last: last};
      pending_vertices.insert(pending_vertices.size(), rq);
   endtask

   task automatic drain();
      while (pending_vertices.size() > 0 || expected_vertices.size() > 0 || busy)
         @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   function automatic int rand_coord();
      int sel;
      sel = $urandom_range(0, 9);
      if (sel < 7) return $urandom_range(0, 6000) - 3000;
      if (sel < 9) return int'($signed(16'($urandom)));
      case ($urandom_range(0, 3))
         0: return -32768;
         1: return 32767;
         2: return 0;
         default: return -1;
      endcase
   endfunction

   initial begin
      logic [31:0] wv[NUM_WIN_REGS];
      int n, total, cx, cy, rad;
      for (int k = 0; k < NUM_WIN_REGS; k++) win_vert[k] = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset window: every edge degenerate, all passes through
      add_vertex(32767, -32768, 1);
      add_vertex(-32768, 32767, 0);
      add_vertex(0, -1, 1);
      for (int i = 0; i < 17; i++) add_vertex(i * 100, -i * 50, i == 16);
      drain();

      // square window
      wv = '{{16'(-800), 16'(-800)}, {16'(800), 16'(-800)}, {16'(800), 16'(800)},
             {16'(-800), 16'(800)}, 32'd0, 32'd0, 32'd0};
      set_window(3'd4, wv);
      add_vertex(0, 0, 0);
      add_vertex(2000, 100, 0);
      add_vertex(-300, 1500, 1);
      add_vertex(3000, 3000, 0);
      add_vertex(4000, 3000, 0);
      add_vertex(3500, 5000, 1);
      drain();
      total = 26;

      while (total < 270) begin
         cx = $urandom_range(0, 2000) - 1000;
         cy = $urandom_range(0, 2000) - 1000;
         rad = $urandom_range(200, 3000);
         for (int k = 0; k < NUM_WIN_REGS; k++) begin
            case ($urandom_range(0, 9))
               0: wv[k] = $urandom;
               1: wv[k] = (k % 2) ? 32'h7fff_8000 : 32'h8000_7fff;
               default: wv[k] = {16'(cx + int'($urandom_range(0, 2 * rad)) - rad),
                                 16'(cy + int'($urandom_range(0, 2 * rad)) - rad)};
            endcase
         end
         if (total > 220) no_gaps = 1'b1;
         set_window(3'($urandom_range(0, 7)), wv);
         for (int p = 0; p < 4; p++) begin
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 20) : $urandom_range(1, 8);
            for (int i = 0; i < n; i++) add_vertex(rand_coord(), rand_coord(), i == n - 1);
            total += n;
         end
         drain();
      end

      drain();
      if (expected_vertices.size() != 0) report("results still expected at end");
      if (mismatches == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end
endmodule
`default_nettype wire
